// ===== src/block_cache_tag_table_lru_macros.svh =====
// assertion macros used by the tag table rtl
`ifndef BLOCK_CACHE_TAG_TABLE_LRU_MACROS_SVH
`define BLOCK_CACHE_TAG_TABLE_LRU_MACROS_SVH

// same-cycle implication, checked out of reset
`define BTT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define BTT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/btt_pkg.sv =====
// types, constants and helpers of the block cache tag table
package btt_pkg;

  localparam int unsigned NUM_SLOTS_DEF = 32;
  localparam int unsigned NUM_SLOTS_MAX = 64;
  localparam int unsigned SLOT_W        = 5;
  localparam int unsigned SLOT_IDX_W    = $clog2(NUM_SLOTS_MAX);
  localparam int unsigned KIND_W        = 3;
  localparam int unsigned DEV_W         = 8;
  localparam int unsigned BLK_W         = 32;
  localparam int unsigned REFS_W        = 8;
  localparam int unsigned STAMP_W       = 32;
  localparam int unsigned STATUS_W      = 2;

  localparam logic [REFS_W-1:0]  REFS_MAX   = '1;
  localparam logic [STAMP_W-1:0] STAMP_ONES = '1;

  typedef enum logic [KIND_W-1:0] {
    KIND_GET     = 3'd0,
    KIND_WRITE   = 3'd1,
    KIND_RELEASE = 3'd2,
    KIND_PIN     = 3'd3,
    KIND_UNPIN   = 3'd4,
    KIND_TICK    = 3'd5
  } btt_kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NO_FREE   = 2'd1,
    STATUS_UNDERFLOW = 2'd2
  } btt_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } btt_state_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [DEV_W-1:0]  device_id;
    logic [BLK_W-1:0]  block_number;
    logic [SLOT_W-1:0] slot_index;
  } btt_in_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   result_slot;
    logic                was_hit;
    logic                read_request;
    logic                write_request;
    logic [REFS_W-1:0]   ref_after;
    logic [STATUS_W-1:0] status;
  } btt_out_t;

  // search wave handed from cell to cell
  typedef struct packed {
    logic                  valid;
    logic                  hit;
    logic [SLOT_IDX_W-1:0] hit_idx;
    logic [REFS_W-1:0]     hit_refs;
    logic                  hit_valid;
    logic                  free;
    logic [SLOT_IDX_W-1:0] free_idx;
    logic [STAMP_W-1:0]    free_stamp;
    logic [REFS_W-1:0]     addr_refs;
  } btt_carry_t;

  // entry write broadcast to the cells
  typedef struct packed {
    logic                  en;
    logic [SLOT_IDX_W-1:0] idx;
    logic                  wr_tag;
    logic [DEV_W-1:0]      dev;
    logic [BLK_W-1:0]      blk;
    logic                  wr_stamp;
    logic [STAMP_W-1:0]    stamp;
    logic [REFS_W-1:0]     refs;
    logic                  wr_valid;
  } btt_upd_t;

  function automatic logic [REFS_W-1:0] refs_inc(input logic [REFS_W-1:0] r);
    return (r == REFS_MAX) ? r : r + 1'b1;
  endfunction

endpackage

// ===== src/btt_cell.sv =====
// one tag table entry and its stage of the search wave
module btt_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  btt_pkg::btt_in_t    query,
  input  btt_pkg::btt_carry_t carry_i,
  output btt_pkg::btt_carry_t carry_o,
  input  btt_pkg::btt_upd_t   upd
);
  import btt_pkg::*;

  localparam logic [SLOT_IDX_W-1:0] MY_IDX = SLOT_IDX_W'(IDX);

  logic [DEV_W-1:0]   dev_r;
  logic [BLK_W-1:0]   blk_r;
  logic               valid_r;
  logic [REFS_W-1:0]  refs_r;
  logic [STAMP_W-1:0] stamp_r;
  btt_carry_t         carry_r;
  btt_carry_t         carry_nxt;
  logic               match;
  logic               qualify;

  assign match   = (dev_r == query.device_id) && (blk_r == query.block_number);
  assign qualify = (refs_r == '0) && (stamp_r != STAMP_ONES) &&
                   (!carry_i.free || (stamp_r <= carry_i.free_stamp));

  always_comb begin
    carry_nxt = carry_i;
    if (!carry_i.hit && match) begin
      carry_nxt.hit       = 1'b1;
      carry_nxt.hit_idx   = MY_IDX;
      carry_nxt.hit_refs  = refs_r;
      carry_nxt.hit_valid = valid_r;
    end
    // later slots win ties
    if (qualify) begin
      carry_nxt.free       = 1'b1;
      carry_nxt.free_idx   = MY_IDX;
      carry_nxt.free_stamp = stamp_r;
    end
    if (SLOT_IDX_W'(query.slot_index) == MY_IDX) begin
      carry_nxt.addr_refs = refs_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carry_r <= '0;
    end else begin
      carry_r <= carry_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_r   <= '0;
      blk_r   <= '0;
      valid_r <= 1'b0;
      refs_r  <= '0;
      stamp_r <= '0;
    end else if (upd.en && (upd.idx == MY_IDX)) begin
      refs_r <= upd.refs;
      if (upd.wr_tag) begin
        dev_r <= upd.dev;
        blk_r <= upd.blk;
      end
      if (upd.wr_stamp) begin
        stamp_r <= upd.stamp;
      end
      if (upd.wr_valid) begin
        valid_r <= 1'b1;
      end
    end
  end

  assign carry_o = carry_r;

endmodule

// ===== src/btt_ctrl.sv =====
// sequencer: item intake, wave launch, result and entry update, time counter
`include "block_cache_tag_table_lru_macros.svh"

module btt_ctrl #(
  parameter int unsigned NUM_SLOTS = btt_pkg::NUM_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  btt_pkg::btt_in_t    in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output btt_pkg::btt_out_t   out_data,
  output btt_pkg::btt_in_t    query,
  output btt_pkg::btt_carry_t head,
  input  btt_pkg::btt_carry_t tail,
  output btt_pkg::btt_upd_t   upd
);
  import btt_pkg::*;

  localparam int unsigned CMP_W = SLOT_IDX_W + 1;

  btt_state_t         state_r;
  btt_state_t         state_nxt;
  btt_in_t            q_r;
  logic               launch_r;
  logic [STAMP_W-1:0] time_r;
  logic [STAMP_W-1:0] time_nxt;
  btt_out_t           res_r;
  btt_out_t           res;
  btt_out_t           out_data_r;
  logic               out_valid_r;
  logic               out_free;
  logic               finish;
  logic               load_out;
  logic               load_res;
  logic               slot_ok;
  logic [REFS_W-1:0]  hit_refs_inc;

  assign in_ready     = (state_r == ST_IDLE);
  assign out_free     = !out_valid_r || out_ready;
  assign finish       = (state_r == ST_SCAN) && tail.valid;
  assign slot_ok      = CMP_W'(q_r.slot_index) < CMP_W'(NUM_SLOTS);
  assign hit_refs_inc = refs_inc(tail.hit_refs);

  always_comb begin
    head       = '0;
    head.valid = launch_r;
  end

  always_comb begin
    res      = '0;
    upd      = '0;
    time_nxt = time_r;
    upd.idx  = SLOT_IDX_W'(q_r.slot_index);
    upd.dev  = q_r.device_id;
    upd.blk  = q_r.block_number;
    upd.stamp = time_r;
    case (q_r.kind)
      KIND_GET: begin
        if (tail.hit) begin
          upd.en           = finish;
          upd.idx          = tail.hit_idx;
          upd.wr_stamp     = 1'b1;
          upd.wr_valid     = 1'b1;
          upd.refs         = hit_refs_inc;
          res.result_slot  = tail.hit_idx[SLOT_W-1:0];
          res.was_hit      = 1'b1;
          res.read_request = !tail.hit_valid;
          res.ref_after    = hit_refs_inc;
        end else if (tail.free) begin
          upd.en           = finish;
          upd.idx          = tail.free_idx;
          upd.wr_tag       = 1'b1;
          upd.wr_stamp     = 1'b1;
          upd.wr_valid     = 1'b1;
          upd.refs         = REFS_W'(1);
          res.result_slot  = tail.free_idx[SLOT_W-1:0];
          res.read_request = 1'b1;
          res.ref_after    = REFS_W'(1);
        end else begin
          res.status = STATUS_NO_FREE;
        end
      end
      KIND_TICK: begin
        if (finish) begin
          time_nxt = time_r + 1'b1;
        end
      end
      KIND_WRITE, KIND_RELEASE, KIND_PIN, KIND_UNPIN: begin
        res.result_slot = q_r.slot_index;
        if (slot_ok) begin
          upd.en = finish;
          case (q_r.kind)
            KIND_WRITE: begin
              upd.wr_stamp      = 1'b1;
              upd.refs          = tail.addr_refs;
              res.write_request = 1'b1;
              res.ref_after     = tail.addr_refs;
            end
            KIND_PIN: begin
              upd.refs      = refs_inc(tail.addr_refs);
              res.ref_after = refs_inc(tail.addr_refs);
            end
            default: begin
              if (tail.addr_refs == '0) begin
                upd.refs   = '0;
                res.status = STATUS_UNDERFLOW;
              end else begin
                upd.refs      = tail.addr_refs - 1'b1;
                res.ref_after = tail.addr_refs - 1'b1;
              end
            end
          endcase
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    load_out  = 1'b0;
    load_res  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (tail.valid) begin
          if (out_free) begin
            load_out  = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            load_res  = 1'b1;
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      launch_r    <= 1'b0;
      time_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      launch_r <= in_valid && in_ready;
      time_r   <= time_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q_r <= in_data;
    end
    if (load_res) begin
      res_r <= res;
    end
    if (load_out) begin
      out_data_r <= (state_r == ST_HOLD) ? res_r : res;
    end
  end

  assign query     = q_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `BTT_ASSERT_NXT(a_accept_launches, in_valid && in_ready, launch_r && (state_r == ST_SCAN), "accepted item did not launch a search wave")
  `BTT_ASSERT_NOW(a_wave_in_scan, tail.valid, state_r == ST_SCAN, "search wave left the chain outside a scan")
  `BTT_ASSERT_NOW(a_upd_at_finish, upd.en, finish && (CMP_W'(upd.idx) < CMP_W'(NUM_SLOTS)), "entry update outside wave end or out of range")
  `BTT_ASSERT_NOW(a_out_from_scan, $rose(out_valid_r), ($past(state_r) == ST_SCAN) || ($past(state_r) == ST_HOLD), "result appeared without a finished scan")

endmodule

// ===== src/block_cache_tag_table_lru.sv =====
// Fully associative block buffer tag table with timestamp LRU replacement.
// Each item (get, write, release, pin, unpin, tick) runs one search wave down a
// chain of NUM_SLOTS entry cells, one cell per clock, that finds the lowest
// matching tag, the least recently used unreferenced slot and the addressed
// slot's count; the entry update is written as the wave leaves the chain and
// the result goes to the output register, or to a hold register while that one
// is still full. One item is in work at a time: the next item is accepted only
// once the last result is in the output register. Reset clears every entry and
// the time counter.
module block_cache_tag_table_lru #(
  parameter int unsigned NUM_SLOTS = btt_pkg::NUM_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  btt_pkg::btt_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output btt_pkg::btt_out_t out_data
);
  import btt_pkg::*;

  btt_in_t    query;
  btt_upd_t   upd;
  btt_carry_t chain [NUM_SLOTS+1];

  btt_ctrl #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .query     (query),
    .head      (chain[0]),
    .tail      (chain[NUM_SLOTS]),
    .upd       (upd)
  );

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    btt_cell #(
      .IDX (i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .query   (query),
      .carry_i (chain[i]),
      .carry_o (chain[i+1]),
      .upd     (upd)
    );
  end

endmodule

// ===== sim/block_cache_tag_table_lru_tb.sv =====
// testbench for the block cache tag table: random and directed items checked against a predictor
module block_cache_tag_table_lru_tb;
  import btt_pkg::*;

  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;
  localparam int ITEMS_TOTAL = 1450;
  localparam int SETTLE_CYCLES = 40;
  localparam int KEY_POOL = 40;
  localparam int MAX_GAP = 40;

  class tag_table_tracker;
    logic [DEV_W-1:0]   dev_of   [NUM_SLOTS_DEF];
    logic [BLK_W-1:0]   blk_of   [NUM_SLOTS_DEF];
    logic               valid_of [NUM_SLOTS_DEF];
    logic [REFS_W-1:0]  refs_of  [NUM_SLOTS_DEF];
    logic [STAMP_W-1:0] stamp_of [NUM_SLOTS_DEF];
    logic [STAMP_W-1:0] now;
    btt_out_t expected_replies[$];
    int mismatches;

    function new();
      int i;
      for (i = 0; i < NUM_SLOTS_DEF; i++) begin
        dev_of[i] = '0;
        blk_of[i] = '0;
        valid_of[i] = 1'b0;
        refs_of[i] = '0;
        stamp_of[i] = '0;
      end
      now = '0;
      mismatches = 0;
    endfunction

    function btt_out_t predict_reply(btt_in_t it);
      btt_out_t r;
      int pick;
      int i;
      int s;
      logic [STAMP_W-1:0] oldest;
      r = '0;
      pick = -1;
      s = it.slot_index;
      if (it.kind == KIND_GET) begin
        for (i = 0; i < NUM_SLOTS_DEF; i++)
          if (pick < 0 && dev_of[i] == it.device_id && blk_of[i] == it.block_number) pick = i;
        if (pick >= 0) begin
          if (refs_of[pick] != REFS_MAX) refs_of[pick] = refs_of[pick] + 1'b1;
          stamp_of[pick] = now;
          r.read_request = !valid_of[pick];
          valid_of[pick] = 1'b1;
          r.result_slot = SLOT_W'(pick);
          r.was_hit = 1'b1;
          r.ref_after = refs_of[pick];
        end else begin
          oldest = STAMP_ONES;
          for (i = NUM_SLOTS_DEF - 1; i >= 0; i--)
            if (refs_of[i] == 0 && stamp_of[i] < oldest) begin
              oldest = stamp_of[i];
              pick = i;
            end
          if (pick < 0) begin
            r.status = STATUS_NO_FREE;
          end else begin
            dev_of[pick] = it.device_id;
            blk_of[pick] = it.block_number;
            stamp_of[pick] = now;
            refs_of[pick] = REFS_W'(1);
            valid_of[pick] = 1'b1;
            r.result_slot = SLOT_W'(pick);
            r.read_request = 1'b1;
            r.ref_after = REFS_W'(1);
          end
        end
      end else if (it.kind == KIND_TICK) begin
        now = now + 1'b1;
      end else if (it.kind == KIND_SPARE_LO || it.kind == KIND_SPARE_HI) begin
        r = '0;
      end else if (s >= NUM_SLOTS_DEF) begin
        r.result_slot = SLOT_W'(s);
      end else begin
        r.result_slot = SLOT_W'(s);
        case (it.kind)
          KIND_WRITE: begin
            stamp_of[s] = now;
            r.write_request = 1'b1;
          end
          KIND_PIN: begin
            if (refs_of[s] != REFS_MAX) refs_of[s] = refs_of[s] + 1'b1;
          end
          default: begin
            if (refs_of[s] == 0) r.status = STATUS_UNDERFLOW;
            else refs_of[s] = refs_of[s] - 1'b1;
          end
        endcase
        r.ref_after = refs_of[s];
      end
      return r;
    endfunction

    function void note_request(btt_in_t it);
      expected_replies.push_back(predict_reply(it));
    endfunction

    function void report(string what, btt_out_t want, btt_out_t got);
      mismatches++;
      if (mismatches <= 10) begin
        $display("tag table %s: exp slot %0d hit %0d rd %0d wr %0d refs %0d st %0d", what,
                 want.result_slot, want.was_hit, want.read_request, want.write_request,
                 want.ref_after, want.status);
        $display("  got slot %0d hit %0d rd %0d wr %0d refs %0d st %0d",
                 got.result_slot, got.was_hit, got.read_request, got.write_request,
                 got.ref_after, got.status);
      end
    endfunction

    function void check_reply(btt_out_t got);
      btt_out_t want;
      if (expected_replies.size() == 0) begin
        report("unexpected item", '0, got);
        return;
      end
      want = expected_replies.pop_front();
      if (got.result_slot !== want.result_slot || got.was_hit !== want.was_hit ||
          got.read_request !== want.read_request || got.write_request !== want.write_request ||
          got.ref_after !== want.ref_after || got.status !== want.status)
        report("mismatch", want, got);
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  btt_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  btt_out_t out_data;

  bit idle_on = 1'b1;
  int sent = 0;
  tag_table_tracker tracker;
  logic [DEV_W-1:0] pool_dev [KEY_POOL];
  logic [BLK_W-1:0] pool_blk [KEY_POOL];

  block_cache_tag_table_lru dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= !idle_on || ($urandom_range(99) >= 35);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) tracker.check_reply(out_data);
  end

  function automatic btt_in_t item_of(input logic [KIND_W-1:0] k, input logic [DEV_W-1:0] d,
                                      input logic [BLK_W-1:0] b, input logic [SLOT_W-1:0] s);
    btt_in_t it;
    it.kind = k;
    it.device_id = d;
    it.block_number = b;
    it.slot_index = s;
    return it;
  endfunction

  function automatic btt_in_t rand_item(input logic [KIND_W-1:0] k);
    return item_of(k, DEV_W'($urandom), $urandom, SLOT_W'($urandom));
  endfunction

  function automatic int free_slots();
    int i;
    int n;
    n = 0;
    for (i = 0; i < NUM_SLOTS_DEF; i++)
      if (tracker.refs_of[i] == 0) n++;
    return n;
  endfunction

  function automatic int held_slot();
    int base;
    int k;
    int s;
    base = $urandom_range(NUM_SLOTS_DEF - 1);
    for (k = 0; k < NUM_SLOTS_DEF; k++) begin
      s = (base + k) % NUM_SLOTS_DEF;
      if (tracker.refs_of[s] != 0) return s;
    end
    return base;
  endfunction

  task automatic send_item(input btt_in_t it);
    int gap;
    gap = 0;
    idle_on = !(sent >= 500 && sent < 800);
    if (idle_on && $urandom_range(99) < 35) gap = $urandom_range(MAX_GAP, 1);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    tracker.note_request(it);
    sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic run_directed();
    send_item(item_of(KIND_GET, 8'h00, 32'h0000_0000, 5'd0));
    send_item(item_of(KIND_GET, 8'hff, 32'hffff_ffff, 5'd31));
    send_item(item_of(KIND_GET, 8'h5a, 32'h0000_1234, 5'd0));
    send_item(item_of(KIND_GET, 8'hff, 32'hffff_ffff, 5'd0));
    send_item(item_of(KIND_TICK, 8'hff, 32'hffff_ffff, 5'd31));
    send_item(item_of(KIND_WRITE, 8'h00, 32'h0000_0000, 5'd31));
    send_item(item_of(KIND_WRITE, 8'h00, 32'h0000_0000, 5'd0));
    send_item(item_of(KIND_PIN, 8'h00, 32'h0000_0000, 5'd0));
    send_item(item_of(KIND_UNPIN, 8'h00, 32'h0000_0000, 5'd0));
    send_item(item_of(KIND_RELEASE, 8'h00, 32'h0000_0000, 5'd0));
    send_item(item_of(KIND_RELEASE, 8'h00, 32'h0000_0000, 5'd0));
    send_item(item_of(KIND_UNPIN, 8'h00, 32'h0000_0000, 5'd5));
    send_item(item_of(KIND_PIN, 8'h00, 32'h0000_0000, 5'd31));
    send_item(item_of(KIND_SPARE_LO, 8'h3c, 32'h5555_aaaa, 5'd17));
    send_item(item_of(KIND_SPARE_HI, 8'hff, 32'hffff_ffff, 5'd31));
    send_item(item_of(KIND_TICK, 8'h00, 32'h0000_0000, 5'd0));
    send_item(item_of(KIND_GET, 8'ha5, 32'h8000_0000, 5'd0));
    send_item(item_of(KIND_GET, 8'h00, 32'h0000_0000, 5'd0));
    repeat (3) send_item(item_of(KIND_RELEASE, 8'h00, 32'h0000_0000, 5'd31));
    send_item(item_of(KIND_GET, 8'h01, 32'h0000_0001, 5'd0));
    send_item(item_of(KIND_WRITE, 8'hff, 32'hffff_ffff, 5'd31));
  endtask

  task automatic pin_burst();
    int s;
    s = $urandom_range(NUM_SLOTS_DEF - 1);
    repeat (258) send_item(item_of(KIND_PIN, DEV_W'($urandom), $urandom, SLOT_W'(s)));
    repeat (3) send_item(item_of(KIND_GET, tracker.dev_of[s], tracker.blk_of[s],
                                 SLOT_W'($urandom)));
    repeat (262) send_item(item_of(KIND_UNPIN, DEV_W'($urandom), $urandom, SLOT_W'(s)));
  endtask

  task automatic fill_then_drain();
    int n;
    int s;
    n = free_slots() + 2;
    repeat (n) send_item(rand_item(KIND_GET));
    for (s = 0; s < NUM_SLOTS_DEF; s++)
      while (tracker.refs_of[s] != 0 && tracker.refs_of[s] <= 4)
        send_item(item_of(KIND_RELEASE, DEV_W'($urandom), $urandom, SLOT_W'(s)));
  endtask

  task automatic random_item();
    int pick;
    int k;
    btt_in_t it;
    pick = $urandom_range(99);
    k = $urandom_range(KEY_POOL - 1);
    if (free_slots() < 5 && pick < 45) pick = 50;
    if (pick < 38) begin
      it = rand_item(KIND_GET);
      it.device_id = pool_dev[k];
      it.block_number = pool_blk[k];
    end else if (pick < 42) begin
      it = rand_item(KIND_GET);
    end else if (pick < 56) begin
      it = rand_item(KIND_RELEASE);
      it.slot_index = SLOT_W'(held_slot());
    end else if (pick < 64) begin
      it = rand_item(KIND_UNPIN);
      it.slot_index = SLOT_W'(held_slot());
    end else if (pick < 69) begin
      it = rand_item(KIND_PIN);
    end else if (pick < 78) begin
      it = rand_item(KIND_WRITE);
    end else if (pick < 88) begin
      it = rand_item(KIND_TICK);
    end else if (pick < 92) begin
      it = rand_item(pick[0] ? KIND_SPARE_HI : KIND_SPARE_LO);
    end else begin
      it = rand_item(pick[0] ? KIND_RELEASE : KIND_UNPIN);
    end
    send_item(it);
  endtask

  initial begin
    #20_000_000;
    $display("block_cache_tag_table_lru_tb: errors");
    $finish;
  end

  initial begin
    int i;
    int next_fill;
    bit burst_done;
    bit paused;
    tracker = new();
    pool_dev[0] = 8'h00;
    pool_blk[0] = 32'h0000_0000;
    pool_dev[1] = 8'hff;
    pool_blk[1] = 32'hffff_ffff;
    for (i = 2; i < KEY_POOL; i++) begin
      pool_dev[i] = DEV_W'($urandom_range(3));
      pool_blk[i] = (i % 2) ? $urandom_range(63) : $urandom;
    end
    next_fill = 200;
    burst_done = 1'b0;
    paused = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    wait_drained();
    while (sent < ITEMS_TOTAL) begin
      if (sent >= 300 && !burst_done) begin
        pin_burst();
        burst_done = 1'b1;
      end else if (sent >= next_fill) begin
        fill_then_drain();
        next_fill += 280;
      end else if (sent >= 1000 && !paused) begin
        wait_drained();
        paused = 1'b1;
      end else begin
        random_item();
      end
    end
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0)
      $display("block_cache_tag_table_lru_tb: clean");
    else
      $display("block_cache_tag_table_lru_tb: errors");
    $finish;
  end
endmodule
